// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module of this project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/fpbd_pkg.sv =====
// ---------------------------------------------------------------------------
// fpbd_pkg
// Types and constants shared by the pulse-width bit deframer modules.
// ---------------------------------------------------------------------------
package fpbd_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_LONG_MIN         = 3'd0,
		REG_LONG_MAX         = 3'd1,
		REG_SHORT_MIN        = 3'd2,
		REG_SHORT_FIRST_MAX  = 3'd3,
		REG_SHORT_SECOND_MAX = 3'd4
	} reg_index_t;

	localparam int unsigned REG_INDEX_BITS = 3;

	// Reset values of the pulse windows (microseconds)
	localparam int unsigned LONG_MIN_RST         = 400;
	localparam int unsigned LONG_MAX_RST         = 650;
	localparam int unsigned SHORT_MIN_RST        = 140;
	localparam int unsigned SHORT_FIRST_MAX_RST  = 350;
	localparam int unsigned SHORT_SECOND_MAX_RST = 330;

	// Bit symbols passed from the classifier to the framer
	typedef enum logic [1:0] {
		SYM_ZERO = 2'd0,
		SYM_ONE  = 2'd1,
		SYM_ERR  = 2'd2
	} sym_t;

	// Framing phase
	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_DATA  = 2'd1,
		PH_STOP  = 2'd2,
		PH_START = 2'd3
	} phase_t;

	// Result event codes
	typedef enum logic [1:0] {
		EV_BYTE      = 2'd0,
		EV_END_OK    = 2'd1,
		EV_MSG_ERR   = 2'd2,
		EV_NO_SIGNAL = 2'd3
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t    kind;
		logic [7:0]  data;
		logic [7:0]  total;
	} event_t;

	// Symbol queue status seen by the front end
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	localparam int unsigned SYM_Q_DEPTH = 4;
	localparam int unsigned SYM_Q_AW    = 2;

endpackage

// ===== rtl/fsk_pulse_bit_deframer.sv =====
// ---------------------------------------------------------------------------
// fsk_pulse_bit_deframer
// Pulse-width FSK deframer: classifies pulse widths into bits and frames
// them into bytes and message events.
// ---------------------------------------------------------------------------
//  channel   | handshake      | payload
//  ----------+----------------+----------------------------------------
//  pulses    | push / full    | pulse_width[PULSE_BITS-1:0]
//  results   | pop / empty    | event_kind[1:0], data_byte, byte_total
//  config    | wr_en          | wr_index[2:0], wr_data[PULSE_BITS-1:0]
//
//  One pulse accepted per cycle while full is low; the framer retires one
//  symbol per cycle while symbols wait and the result queue is not full.
//  A four-entry symbol queue parts classifier and framer; a two-entry result
//  queue parts framer and output, so a stalled pop fills both before full.
//  Reset is asynchronous and clears windows to their defaults and all framing.
// ---------------------------------------------------------------------------
module fsk_pulse_bit_deframer import fpbd_pkg::*; #(
	parameter int unsigned PULSE_BITS = 14
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [REG_INDEX_BITS-1:0] wr_index,
	input  logic [PULSE_BITS-1:0]     wr_data,
	input  logic                      push,
	input  logic [PULSE_BITS-1:0]     pulse_width,
	output logic                      full,
	input  logic                      pop,
	output logic                      empty,
	output logic [1:0]                event_kind,
	output logic [7:0]                data_byte,
	output logic [7:0]                byte_total
);

	q_status_t sym_status;
	logic      sym_push, sym_pop;
	sym_t      sym_wdata, sym_rdata;
	ev_kind_t  ev_kind;

	fpbd_classifier #(.PULSE_BITS(PULSE_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.push        (push),
		.pulse_width (pulse_width),
		.full        (full),
		.sym_status  (sym_status),
		.sym_push    (sym_push),
		.sym_data    (sym_wdata)
	);

	fpbd_sym_fifo u_sym_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (sym_push),
		.wdata  (sym_wdata),
		.rd     (sym_pop),
		.rdata  (sym_rdata),
		.status (sym_status)
	);

	fpbd_framer u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.sym_empty  (sym_status.empty),
		.sym        (sym_rdata),
		.sym_pop    (sym_pop),
		.pop        (pop),
		.empty      (empty),
		.event_kind (ev_kind),
		.data_byte  (data_byte),
		.byte_total (byte_total)
	);

	assign event_kind = ev_kind;

endmodule

// ===== rtl/fpbd_classifier.sv =====
// ---------------------------------------------------------------------------
// fpbd_classifier
// Front end: holds the pulse windows, accepts pulse widths and turns them
// into bit symbols (one, zero from a short pair, or error).
// ---------------------------------------------------------------------------
module fpbd_classifier import fpbd_pkg::*; #(
	parameter int unsigned PULSE_BITS = 14
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration writes
	input  logic                      wr_en,
	input  logic [REG_INDEX_BITS-1:0] wr_index,
	input  logic [PULSE_BITS-1:0]     wr_data,
	// pulse input
	input  logic                      push,
	input  logic [PULSE_BITS-1:0]     pulse_width,
	output logic                      full,
	// symbol queue side
	input  q_status_t                 sym_status,
	output logic                      sym_push,
	output sym_t                      sym_data
);

	logic [PULSE_BITS-1:0] long_min_q, long_max_q, short_min_q;
	logic [PULSE_BITS-1:0] short_first_max_q, short_second_max_q;
	logic                  short_pending_q;
	logic                  short_pending_d;
	logic                  accept;
	logic                  in_long, in_short1, in_short2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_min_q         <= PULSE_BITS'(LONG_MIN_RST);
			long_max_q         <= PULSE_BITS'(LONG_MAX_RST);
			short_min_q        <= PULSE_BITS'(SHORT_MIN_RST);
			short_first_max_q  <= PULSE_BITS'(SHORT_FIRST_MAX_RST);
			short_second_max_q <= PULSE_BITS'(SHORT_SECOND_MAX_RST);
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_LONG_MIN:         long_min_q         <= wr_data;
				REG_LONG_MAX:         long_max_q         <= wr_data;
				REG_SHORT_MIN:        short_min_q        <= wr_data;
				REG_SHORT_FIRST_MAX:  short_first_max_q  <= wr_data;
				REG_SHORT_SECOND_MAX: short_second_max_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Window tests, all bounds exclusive
	assign in_long   = (pulse_width > long_min_q)  && (pulse_width < long_max_q);
	assign in_short1 = (pulse_width > short_min_q) && (pulse_width < short_first_max_q);
	assign in_short2 = (pulse_width > short_min_q) && (pulse_width < short_second_max_q);

	assign full   = sym_status.full;
	assign accept = push && !sym_status.full;

	// Classification; a first short half only arms short_pending
	always_comb begin
		sym_push        = 1'b0;
		sym_data        = SYM_ERR;
		short_pending_d = short_pending_q;
		if (accept) begin
			if (short_pending_q) begin
				short_pending_d = 1'b0;
				sym_push        = 1'b1;
				sym_data        = in_short2 ? SYM_ZERO : SYM_ERR;
			end else if (in_long) begin
				sym_push = 1'b1;
				sym_data = SYM_ONE;
			end else if (in_short1) begin
				short_pending_d = 1'b1;
			end else begin
				sym_push = 1'b1;
				sym_data = SYM_ERR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_pending_q <= 1'b0;
		end else begin
			short_pending_q <= short_pending_d;
		end
	end

endmodule

// ===== rtl/fpbd_sym_fifo.sv =====
// ---------------------------------------------------------------------------
// fpbd_sym_fifo
// Short queue of bit symbols between the classifier and the framer.
// ---------------------------------------------------------------------------
module fpbd_sym_fifo import fpbd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  sym_t      wdata,
	input  logic      rd,
	output sym_t      rdata,
	output q_status_t status
);

	sym_t                mem_q [SYM_Q_DEPTH];
	logic [SYM_Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [SYM_Q_AW:0]   count_q;
	logic                do_wr, do_rd;

	assign status.full  = (count_q == (SYM_Q_AW+1)'(SYM_Q_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_wr = wr && !status.full;
	assign do_rd = rd && !status.empty;
	assign rdata = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + SYM_Q_AW'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + SYM_Q_AW'(1);
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + (SYM_Q_AW+1)'(1);
				2'b01:   count_q <= count_q - (SYM_Q_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/fpbd_framer.sv =====
// ---------------------------------------------------------------------------
// fpbd_framer
// Back end: frames bit symbols into bytes and message events, with a
// two-entry result queue towards the output.
// ---------------------------------------------------------------------------
module fpbd_framer import fpbd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	// symbol queue side
	input  logic     sym_empty,
	input  sym_t     sym,
	output logic     sym_pop,
	// result side
	input  logic     pop,
	output logic     empty,
	output ev_kind_t event_kind,
	output logic [7:0] data_byte,
	output logic [7:0] byte_total
);

	phase_t     phase_q, phase_d;
	logic [2:0] bit_idx_q, bit_idx_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] count_q, count_d;
	logic       emit;
	event_t     ev;
	logic [7:0] shift_set;
	logic [7:0] count_inc;

	event_t     ob_q [2];
	logic       ob_wr_q, ob_rd_q;
	logic [1:0] ob_cnt_q;
	logic       ob_full, ob_pop;

	assign ob_full = (ob_cnt_q == 2'd2);
	assign sym_pop = !sym_empty && !ob_full;
	assign shift_set = shift_q | (8'd1 << bit_idx_q);
	assign count_inc = (count_q == 8'hFF) ? count_q : count_q + 8'd1;

	// Framing state machine: next state and event
	always_comb begin
		phase_d   = phase_q;
		bit_idx_d = bit_idx_q;
		shift_d   = shift_q;
		count_d   = count_q;
		emit      = 1'b0;
		ev        = '{kind: EV_END_OK, data: 8'd0, total: count_q};
		if (sym_pop) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (sym == SYM_ERR) begin
						emit = 1'b1;
						ev   = '{kind: EV_NO_SIGNAL, data: 8'd0, total: 8'd0};
					end else if (sym == SYM_ZERO) begin
						count_d   = 8'd0;
						phase_d   = PH_DATA;
						bit_idx_d = 3'd0;
						shift_d   = 8'd0;
					end
				end
				PH_DATA: begin
					if (sym == SYM_ERR) begin
						emit      = 1'b1;
						ev        = '{kind: EV_MSG_ERR, data: 8'd0, total: count_q};
						phase_d   = PH_HUNT;
						count_d   = 8'd0;
						bit_idx_d = 3'd0;
						shift_d   = 8'd0;
					end else begin
						if (sym == SYM_ONE) shift_d = shift_set;
						if (bit_idx_q == 3'd7) begin
							bit_idx_d = 3'd0;
							count_d   = count_inc;
							phase_d   = PH_STOP;
							emit      = 1'b1;
							ev        = '{kind: EV_BYTE, data: shift_d, total: count_inc};
						end else begin
							bit_idx_d = bit_idx_q + 3'd1;
						end
					end
				end
				PH_STOP: begin
					if (sym == SYM_ONE) begin
						phase_d = PH_START;
					end else begin
						emit      = 1'b1;
						phase_d   = PH_HUNT;
						count_d   = 8'd0;
						bit_idx_d = 3'd0;
						shift_d   = 8'd0;
					end
				end
				PH_START: begin
					if (sym == SYM_ZERO) begin
						phase_d   = PH_DATA;
						bit_idx_d = 3'd0;
						shift_d   = 8'd0;
					end else begin
						emit      = 1'b1;
						phase_d   = PH_HUNT;
						count_d   = 8'd0;
						bit_idx_d = 3'd0;
						shift_d   = 8'd0;
					end
				end
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	// Framing state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			bit_idx_q <= 3'd0;
			shift_q   <= 8'd0;
			count_q   <= 8'd0;
		end else begin
			phase_q   <= phase_d;
			bit_idx_q <= bit_idx_d;
			shift_q   <= shift_d;
			count_q   <= count_d;
		end
	end

	// Result queue, two entries
	assign empty      = (ob_cnt_q == 2'd0);
	assign ob_pop     = pop && !empty;
	assign event_kind = ob_q[ob_rd_q].kind;
	assign data_byte  = ob_q[ob_rd_q].data;
	assign byte_total = ob_q[ob_rd_q].total;

	always_ff @(posedge clk) begin
		if (emit) begin
			ob_q[ob_wr_q] <= ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wr_q  <= 1'b0;
			ob_rd_q  <= 1'b0;
			ob_cnt_q <= 2'd0;
		end else begin
			if (emit)   ob_wr_q <= ~ob_wr_q;
			if (ob_pop) ob_rd_q <= ~ob_rd_q;
			case ({emit, ob_pop})
				2'b10:   ob_cnt_q <= ob_cnt_q + 2'd1;
				2'b01:   ob_cnt_q <= ob_cnt_q - 2'd1;
				default: ob_cnt_q <= ob_cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/fpbd_checker.sv =====
// ---------------------------------------------------------------------------
// fpbd_checker
// Port-level checks on the deframer's result channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fpbd_checker import fpbd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       pop,
	input logic       empty,
	input logic [1:0] event_kind,
	input logic [7:0] data_byte,
	input logic [7:0] byte_total
);

	// Only byte events carry data
	`ASSERT_IMPLIES(a_data_only_on_byte, clk, arst_n, !empty && event_kind != EV_BYTE, data_byte == 8'd0)

	// No-signal events carry no byte count
	`ASSERT_IMPLIES(a_nosig_zero_total, clk, arst_n, !empty && event_kind == EV_NO_SIGNAL, byte_total == 8'd0)

	// A byte event has counted at least that byte
	`ASSERT_IMPLIES(a_byte_counted, clk, arst_n, !empty && event_kind == EV_BYTE, byte_total != 8'd0)

	// A waiting result holds until taken
	`ASSERT_NEXT(a_result_holds, clk, arst_n, !empty && !pop, !empty && $stable(event_kind) && $stable(data_byte) && $stable(byte_total))

endmodule

bind fsk_pulse_bit_deframer fpbd_checker u_fpbd_checker (.*);
